// ----- rtl/assert_macros.svh -----
// Assertion macros for the checked RTL (pai_ctrl.sv includes them).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with asynchronous active-low reset disable.
`define PAI_ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Plain condition that must hold on every clock edge out of reset.
`define PAI_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    `PAI_ASSERT_PROP(lbl, clk, rst_n, (expr), msg)

`endif

// ----- rtl/pai_pkg.sv -----
// Package for the packed array insert/delete block: codes, widths and shared types.
package pai_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int WORD_W        = 32;
    localparam int CMD_W         = 3;
    localparam int STATUS_W      = 2;

    localparam logic [CMD_W-1:0] CMD_APPEND   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DEL_POS  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_ONE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_ALL  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ     = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

// ----- rtl/pai_mem.sv -----
// Word store: synchronous RAM, one write and one registered read per cycle.
module pai_mem #(
    parameter int DEPTH = pai_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                              clk,
    input  pai_pkg::mem_ctl_t                 ctl,
    input  logic [AW-1:0]                     waddr,
    input  logic signed [pai_pkg::WORD_W-1:0] wdata,
    input  logic [AW-1:0]                     raddr,
    output logic signed [pai_pkg::WORD_W-1:0] rdata
);

    logic signed [pai_pkg::WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/pai_ctrl.sv -----
// Command sequencer: range checks, shift and compaction walks and single-word reads over the word store.
`include "assert_macros.svh"

module pai_ctrl #(
    parameter int DEPTH = pai_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [pai_pkg::CMD_W-1:0]           cmd,
    input  logic [CW-1:0]                       position,
    input  logic signed [pai_pkg::WORD_W-1:0]   value,
    output logic                                done,
    output logic [pai_pkg::STATUS_W-1:0]        status,
    output logic [CW-1:0]                       live_count,
    output logic [CW-1:0]                       removed_count,
    output logic signed [pai_pkg::WORD_W-1:0]   read_data,
    output pai_pkg::mem_ctl_t                   mem_ctl,
    output logic [AW-1:0]                       mem_waddr,
    output logic signed [pai_pkg::WORD_W-1:0]   mem_wdata,
    output logic [AW-1:0]                       mem_raddr,
    input  logic signed [pai_pkg::WORD_W-1:0]   mem_rdata
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    localparam logic [CW-1:0] ONE  = CW'(1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    logic                              state_reg,   state_next;
    logic [pai_pkg::CMD_W-1:0]         cmd_reg,     cmd_next;
    logic [CW-1:0]                     pos_reg,     pos_next;
    logic signed [pai_pkg::WORD_W-1:0] val_reg,     val_next;
    logic [CW-1:0]                     count_reg,   count_next;
    logic [CW-1:0]                     rd_idx_reg,  rd_idx_next;
    logic [CW-1:0]                     rd_last_reg, rd_last_next;
    logic                              rd_live_reg, rd_live_next;
    logic                              pend_reg,    pend_next;
    logic [CW-1:0]                     src_reg,     src_next;
    logic [CW-1:0]                     keep_reg,    keep_next;
    logic                              found_reg,   found_next;
    logic [CW-1:0]                     rem_reg,     rem_next;
    logic signed [pai_pkg::WORD_W-1:0] cap_reg,     cap_next;

    logic                                done_reg,     done_next;
    logic [pai_pkg::STATUS_W-1:0]        res_st_reg,   res_st_next;
    logic [CW-1:0]                       res_live_reg, res_live_next;
    logic [CW-1:0]                       res_rem_reg,  res_rem_next;
    logic signed [pai_pkg::WORD_W-1:0]   res_data_reg, res_data_next;

    logic          full;
    logic [CW-1:0] eff_pos;
    logic [CW-1:0] src_up;
    logic [CW-1:0] src_dn;
    logic          hit;

    assign full    = (count_reg == FULL);
    assign eff_pos = (cmd == pai_pkg::CMD_APPEND) ? count_reg : position;
    assign src_up  = src_reg + ONE;
    assign src_dn  = src_reg - ONE;
    assign hit     = (mem_rdata == val_reg)
                     && ((cmd_reg == pai_pkg::CMD_DEL_ALL) || !found_reg);

    assign busy          = (state_reg == S_RUN);
    assign done          = done_reg;
    assign status        = res_st_reg;
    assign live_count    = res_live_reg;
    assign removed_count = res_rem_reg;
    assign read_data     = res_data_reg;

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        count_next    = count_reg;
        rd_idx_next   = rd_idx_reg;
        rd_last_next  = rd_last_reg;
        rd_live_next  = rd_live_reg;
        pend_next     = 1'b0;
        src_next      = src_reg;
        keep_next     = keep_reg;
        found_next    = found_reg;
        rem_next      = rem_reg;
        cap_next      = cap_reg;
        done_next     = 1'b0;
        res_st_next   = res_st_reg;
        res_live_next = res_live_reg;
        res_rem_next  = res_rem_reg;
        res_data_next = res_data_reg;
        mem_ctl       = '0;
        mem_waddr     = '0;
        mem_wdata     = val_reg;
        mem_raddr     = rd_idx_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    // default: immediate result, store untouched
                    done_next     = 1'b1;
                    res_st_next   = pai_pkg::ST_OK;
                    res_live_next = count_reg;
                    res_rem_next  = '0;
                    res_data_next = '0;
                    pos_next      = eff_pos;
                    val_next      = value;
                    keep_next     = '0;
                    found_next    = 1'b0;
                    rem_next      = '0;
                    cap_next      = '0;
                    unique case (cmd)
                        pai_pkg::CMD_APPEND, pai_pkg::CMD_INSERT:
                        begin
                            if (full)
                            begin
                                res_st_next = pai_pkg::ST_FULL;
                            end
                            else if (eff_pos > count_reg)
                            begin
                                res_st_next = pai_pkg::ST_RANGE;
                            end
                            else
                            begin
                                done_next    = 1'b0;
                                state_next   = S_RUN;
                                cmd_next     = pai_pkg::CMD_INSERT;
                                rd_live_next = (eff_pos < count_reg);
                                rd_idx_next  = count_reg - ONE;
                                rd_last_next = eff_pos;
                            end
                        end
                        pai_pkg::CMD_DEL_POS:
                        begin
                            if (position >= count_reg)
                            begin
                                res_st_next = pai_pkg::ST_RANGE;
                            end
                            else
                            begin
                                done_next    = 1'b0;
                                state_next   = S_RUN;
                                cmd_next     = cmd;
                                rd_live_next = (position < count_reg - ONE);
                                rd_idx_next  = position + ONE;
                                rd_last_next = count_reg - ONE;
                            end
                        end
                        pai_pkg::CMD_DEL_ONE, pai_pkg::CMD_DEL_ALL:
                        begin
                            done_next    = 1'b0;
                            state_next   = S_RUN;
                            cmd_next     = cmd;
                            rd_live_next = (count_reg != '0);
                            rd_idx_next  = '0;
                            rd_last_next = count_reg - ONE;
                        end
                        pai_pkg::CMD_READ:
                        begin
                            if (position >= count_reg)
                            begin
                                res_st_next = pai_pkg::ST_RANGE;
                            end
                            else
                            begin
                                done_next    = 1'b0;
                                state_next   = S_RUN;
                                cmd_next     = cmd;
                                rd_live_next = 1'b1;
                                rd_idx_next  = position;
                                rd_last_next = position;
                            end
                        end
                        default:
                        begin
                            res_st_next = pai_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_RUN:
            begin
                if (rd_live_reg)
                begin
                    mem_ctl.rd_en = 1'b1;
                    pend_next     = 1'b1;
                    src_next      = rd_idx_reg;
                    if (rd_idx_reg == rd_last_reg)
                    begin
                        rd_live_next = 1'b0;
                    end
                    else if (cmd_reg == pai_pkg::CMD_INSERT)
                    begin
                        rd_idx_next = rd_idx_reg - ONE;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + ONE;
                    end
                end

                if (pend_reg)
                begin
                    mem_wdata = mem_rdata;
                    unique case (cmd_reg)
                        pai_pkg::CMD_INSERT:
                        begin
                            mem_ctl.wr_en = 1'b1;
                            mem_waddr     = src_up[AW-1:0];
                        end
                        pai_pkg::CMD_DEL_POS:
                        begin
                            mem_ctl.wr_en = 1'b1;
                            mem_waddr     = src_dn[AW-1:0];
                        end
                        pai_pkg::CMD_DEL_ONE, pai_pkg::CMD_DEL_ALL:
                        begin
                            if (hit)
                            begin
                                found_next = 1'b1;
                                rem_next   = rem_reg + ONE;
                            end
                            else
                            begin
                                mem_ctl.wr_en = 1'b1;
                                mem_waddr     = keep_reg[AW-1:0];
                                keep_next     = keep_reg + ONE;
                            end
                        end
                        default:
                        begin
                            cap_next = mem_rdata;
                        end
                    endcase
                end

                if (!rd_live_reg && !pend_reg)
                begin
                    state_next    = S_IDLE;
                    done_next     = 1'b1;
                    res_st_next   = pai_pkg::ST_OK;
                    res_live_next = count_reg;
                    res_rem_next  = '0;
                    res_data_next = '0;
                    unique case (cmd_reg)
                        pai_pkg::CMD_INSERT:
                        begin
                            mem_ctl.wr_en = 1'b1;
                            mem_waddr     = pos_reg[AW-1:0];
                            mem_wdata     = val_reg;
                            count_next    = count_reg + ONE;
                            res_live_next = count_reg + ONE;
                        end
                        pai_pkg::CMD_DEL_POS:
                        begin
                            count_next    = count_reg - ONE;
                            res_live_next = count_reg - ONE;
                            res_rem_next  = ONE;
                        end
                        pai_pkg::CMD_DEL_ONE, pai_pkg::CMD_DEL_ALL:
                        begin
                            count_next    = keep_reg;
                            res_live_next = keep_reg;
                            res_rem_next  = rem_reg;
                            if (rem_reg == '0)
                            begin
                                res_st_next = pai_pkg::ST_NOTFOUND;
                            end
                        end
                        default:
                        begin
                            res_data_next = cap_reg;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            rd_live_reg <= 1'b0;
            pend_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_live_reg <= rd_live_next;
            pend_reg    <= pend_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        rd_idx_reg   <= rd_idx_next;
        rd_last_reg  <= rd_last_next;
        src_reg      <= src_next;
        keep_reg     <= keep_next;
        found_reg    <= found_next;
        rem_reg      <= rem_next;
        cap_reg      <= cap_next;
        res_st_reg   <= res_st_next;
        res_live_reg <= res_live_next;
        res_rem_reg  <= res_rem_next;
        res_data_reg <= res_data_next;
    end

    `PAI_ASSERT_ALWAYS(a_no_rw_clash, clk, rst_n,
        !(mem_ctl.wr_en && mem_ctl.rd_en && (mem_waddr == mem_raddr)),
        "read and write hit the same entry")
    `PAI_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= FULL, "live count above depth")
    `PAI_ASSERT_PROP(a_pend_follows_read, clk, rst_n, pend_reg |-> $past(mem_ctl.rd_en),
        "pending word without a read")
    `PAI_ASSERT_PROP(a_idle_no_access, clk, rst_n,
        (state_reg == S_IDLE) |-> !mem_ctl.rd_en && !pend_reg,
        "store read while idle")

endmodule

// ----- rtl/packed_array_insert_delete_top.sv -----
// Top level of the packed array insert/delete block: sequencer plus word store.
//
//  channel   direction  handshake                   fields
//  command   in         start & !busy               cmd, position, value
//  result    out        done (one-cycle strobe)     status, live_count, removed_count,
//                                                   read_data
//
// A command that fails its checks, or an unused code, strobes in the cycle after accept.
// Others walk the store one word per cycle through its single read port, writing each
// word back shifted or compacted, then strobe done; insert and append finish by writing
// the new value. No word is read for an insert at the end, an append, a delete of the
// last word, or a value delete on an empty store. A read captures the addressed word.
// rst_n clears the live count and control; the store has no reset and no clearing pass.
// busy is high while a walk runs; results cannot be held off.
module packed_array_insert_delete_top #(
    parameter int DEPTH = pai_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [pai_pkg::CMD_W-1:0]           cmd,
    input  logic [CW-1:0]                       position,
    input  logic signed [pai_pkg::WORD_W-1:0]   value,
    output logic                                done,
    output logic [pai_pkg::STATUS_W-1:0]        status,
    output logic [CW-1:0]                       live_count,
    output logic [CW-1:0]                       removed_count,
    output logic signed [pai_pkg::WORD_W-1:0]   read_data
);

    pai_pkg::mem_ctl_t                 mem_ctl;
    logic [AW-1:0]                     mem_waddr;
    logic [AW-1:0]                     mem_raddr;
    logic signed [pai_pkg::WORD_W-1:0] mem_wdata;
    logic signed [pai_pkg::WORD_W-1:0] mem_rdata;

    pai_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .position      (position),
        .value         (value),
        .done          (done),
        .status        (status),
        .live_count    (live_count),
        .removed_count (removed_count),
        .read_data     (read_data),
        .mem_ctl       (mem_ctl),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata)
    );

    pai_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .ctl   (mem_ctl),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
